// ===== rtl/qcd_pkg.sv =====
// Shared types and constants for the QOI chunk decoder.
`timescale 1ns / 1ps

package qcd_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int COUNT_BITS_DEF = 32;
	localparam int CMD_Q_DEPTH = 2;
	localparam int RES_Q_DEPTH = 2;
	localparam int RUN_MAX = 62;

	localparam logic [7:0] TAG_RGB = 8'hfe;
	localparam logic [7:0] TAG_RGBA = 8'hff;

	localparam logic [1:0] CL_INDEX = 2'b00;
	localparam logic [1:0] CL_DIFF = 2'b01;
	localparam logic [1:0] CL_LUMA = 2'b10;
	localparam logic [1:0] CL_RUN = 2'b11;

	typedef enum logic [2:0] {
		OP_RGB,
		OP_RGBA,
		OP_INDEX,
		OP_DIFF,
		OP_LUMA,
		OP_RUN,
		OP_CUT
	} op_t;

	typedef enum logic [1:0] {
		ST_PIXEL = 2'd0,
		ST_CUT = 2'd1,
		ST_EARLY = 2'd2
	} status_t;

	typedef struct packed {
		op_t op;
		logic [31:0] arg;
		logic eod;
	} cmd_t;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		status_t status;
		logic lor;
		logic lp;
	} res_t;

endpackage

// ===== rtl/qcd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module qcd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/qcd_fifo.sv =====
// Small flop-based FIFO for words between decoder stages.
`timescale 1ns / 1ps

module qcd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = count_q == CW'(DEPTH);
	assign empty = count_q == '0;
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (!do_push && do_pop) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== rtl/qcd_front.sv =====
// Front end: parses stream bytes into whole-chunk commands.
`timescale 1ns / 1ps

module qcd_front import qcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       end_of_data,
	output logic       cmd_vld,
	output cmd_t       cmd
);

	logic [2:0] pend_q, pend_d;
	logic [7:0] tag_q, tag_d;
	logic [31:0] col_q, col_d;
	logic [2:0] pos;
	logic rgba;

	always_comb begin
		pend_d = pend_q;
		tag_d = tag_q;
		col_d = col_q;
		cmd_vld = 1'b0;
		cmd.op = OP_CUT;
		cmd.arg = '0;
		cmd.eod = end_of_data;
		rgba = tag_q == TAG_RGBA;
		pos = rgba ? 3'd4 - pend_q : 3'd3 - pend_q;

		if (pend_q != 3'd0) begin
			if (tag_q[7:6] == CL_LUMA) begin
				cmd_vld = 1'b1;
				cmd.op = OP_LUMA;
				cmd.arg = {18'd0, tag_q[5:0], data_byte};
				pend_d = 3'd0;
			end else begin
				case (pos)
					3'd0: col_d[23:16] = data_byte;
					3'd1: col_d[15:8] = data_byte;
					3'd2: col_d[7:0] = data_byte;
					default: col_d[31:24] = data_byte;
				endcase
				pend_d = pend_q - 3'd1;
				if (pend_d == 3'd0) begin
					cmd_vld = 1'b1;
					cmd.op = rgba ? OP_RGBA : OP_RGB;
					cmd.arg = col_d;
				end
			end
		end else if (data_byte == TAG_RGB || data_byte == TAG_RGBA) begin
			tag_d = data_byte;
			pend_d = (data_byte == TAG_RGBA) ? 3'd4 : 3'd3;
		end else begin
			case (data_byte[7:6])
				CL_INDEX: begin
					cmd_vld = 1'b1;
					cmd.op = OP_INDEX;
					cmd.arg = 32'(data_byte[5:0]);
				end
				CL_DIFF: begin
					cmd_vld = 1'b1;
					cmd.op = OP_DIFF;
					cmd.arg = 32'(data_byte[5:0]);
				end
				CL_LUMA: begin
					tag_d = data_byte;
					pend_d = 3'd1;
				end
				default: begin
					cmd_vld = 1'b1;
					cmd.op = OP_RUN;
					cmd.arg = 32'(data_byte[5:0]);
				end
			endcase
		end

		// end of data: a chunk still open is reported as cut off
		if (end_of_data) begin
			if (pend_d != 3'd0) begin
				cmd_vld = 1'b1;
				cmd.op = OP_CUT;
				cmd.arg = '0;
			end
			pend_d = 3'd0;
			tag_d = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 3'd0;
			tag_q <= 8'd0;
		end else if (accept) begin
			pend_q <= pend_d;
			tag_q <= tag_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_q <= col_d;
		end
	end

endmodule

// ===== rtl/qcd_back.sv =====
// Back end: executes chunk commands, keeps pixel state and colour table.
`timescale 1ns / 1ps

module qcd_back import qcd_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] pixel_count,
	input  cmd_t        cmd,
	input  logic        cmd_empty,
	output logic        cmd_pop,
	output res_t        res,
	output logic        res_push,
	input  logic        res_full
);

	localparam int TAB_AW = $clog2(TABLE_ENTRIES);

	function automatic logic [TAB_AW-1:0] hash(input logic [31:0] c);
		logic [11:0] s;
		s = 12'd3 * {4'h0, c[23:16]} + 12'd5 * {4'h0, c[15:8]} +
			12'd7 * {4'h0, c[7:0]} + 12'd11 * {4'h0, c[31:24]};
		return s[TAB_AW-1:0];
	endfunction

	// persistent state
	logic [31:0] prev_q;
	logic [COUNT_BITS-1:0] done_q;
	logic cmpl_q;
	logic [TABLE_ENTRIES-1:0] tvalid_q;

	// execute stage
	logic vld_s2;
	logic first_s2;
	logic tail_s2;
	logic [5:0] cnt_s2;
	logic len62_s2;
	cmd_t cmd_s2;
	logic byp_s2;
	logic tv_s2;
	logic [31:0] bdat_s2;

	logic [31:0] ram_rdata;
	logic [31:0] idx_col;
	logic [31:0] new_col;
	logic [7:0] pa, pr, pg, pb, dg;
	logic [COUNT_BITS-1:0] pcm, done_p1, done_p2;
	logic is_lp, nxt_lp, is_cut, pix_ph, stop, need_tail, need_out, item_done, reinit;
	logic tab_we;
	logic [TAB_AW-1:0] tab_waddr;
	logic [TAB_AW-1:0] rd_addr;

	qcd_ram #(
		.WIDTH(32),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (tab_we),
		.waddr (tab_waddr),
		.wdata (new_col),
		.re    (cmd_pop),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	always_comb begin
		pcm = COUNT_BITS'(pixel_count);
		done_p1 = done_q + COUNT_BITS'(1);
		done_p2 = done_q + COUNT_BITS'(2);
		is_lp = done_p1 == pcm;
		nxt_lp = done_p2 == pcm;

		idx_col = byp_s2 ? bdat_s2 : (tv_s2 ? ram_rdata : 32'd0);
		pa = prev_q[31:24];
		pr = prev_q[23:16];
		pg = prev_q[15:8];
		pb = prev_q[7:0];
		dg = {2'b00, cmd_s2.arg[13:8]} - 8'd32;

		case (cmd_s2.op)
			OP_RGB: new_col = {pa, cmd_s2.arg[23:0]};
			OP_RGBA: new_col = cmd_s2.arg;
			OP_INDEX: new_col = idx_col;
			OP_DIFF: new_col = {pa,
				pr + {6'd0, cmd_s2.arg[5:4]} - 8'd2,
				pg + {6'd0, cmd_s2.arg[3:2]} - 8'd2,
				pb + {6'd0, cmd_s2.arg[1:0]} - 8'd2};
			OP_LUMA: new_col = {pa,
				pr + dg + {4'd0, cmd_s2.arg[7:4]} - 8'd8,
				pg + dg,
				pb + dg + {4'd0, cmd_s2.arg[3:0]} - 8'd8};
			default: new_col = prev_q;
		endcase

		is_cut = cmd_s2.op == OP_CUT;
		pix_ph = !is_cut && !tail_s2;
		// a full run on the last byte leaves room for the early-end word
		stop = is_lp || cnt_s2 == 6'd1 ||
			(len62_s2 && cmd_s2.eod && cnt_s2 == 6'd2 && !nxt_lp);
		need_tail = stop && cmd_s2.eod && !is_lp;
		need_out = vld_s2 && !cmpl_q;
		res_push = need_out && !res_full;

		if (pix_ph) begin
			res.a = new_col[31:24];
			res.r = new_col[23:16];
			res.g = new_col[15:8];
			res.b = new_col[7:0];
			res.status = ST_PIXEL;
			res.lor = stop && !need_tail;
			res.lp = is_lp;
		end else begin
			res.a = 8'd0;
			res.r = 8'd0;
			res.g = 8'd0;
			res.b = 8'd0;
			res.status = is_cut ? ST_CUT : ST_EARLY;
			res.lor = 1'b1;
			res.lp = 1'b0;
		end

		item_done = vld_s2 && (cmpl_q || (res_push && (!pix_ph || (stop && !need_tail))));
		reinit = item_done && cmd_s2.eod;
		tab_we = res_push && pix_ph && first_s2;
		tab_waddr = hash(new_col);
		cmd_pop = !cmd_empty && (!vld_s2 || item_done);
		rd_addr = cmd.arg[TAB_AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 32'hff00_0000;
			done_q <= '0;
			cmpl_q <= 1'b0;
			tvalid_q <= '0;
		end else if (reinit) begin
			prev_q <= 32'hff00_0000;
			done_q <= '0;
			cmpl_q <= 1'b0;
			tvalid_q <= '0;
		end else begin
			if (tab_we) begin
				prev_q <= new_col;
				tvalid_q[tab_waddr] <= 1'b1;
			end
			if (res_push && pix_ph) begin
				done_q <= done_p1;
				if (is_lp) begin
					cmpl_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			first_s2 <= 1'b0;
			tail_s2 <= 1'b0;
			cnt_s2 <= 6'd0;
			len62_s2 <= 1'b0;
		end else if (cmd_pop) begin
			vld_s2 <= 1'b1;
			first_s2 <= 1'b1;
			tail_s2 <= 1'b0;
			cnt_s2 <= (cmd.op == OP_RUN) ? cmd.arg[5:0] + 6'd1 : 6'd1;
			len62_s2 <= (cmd.op == OP_RUN) && (cmd.arg[5:0] == 6'(RUN_MAX - 1));
		end else begin
			if (item_done) begin
				vld_s2 <= 1'b0;
			end
			if (res_push) begin
				first_s2 <= 1'b0;
				if (pix_ph) begin
					cnt_s2 <= cnt_s2 - 6'd1;
				end
				if (pix_ph && need_tail) begin
					tail_s2 <= 1'b1;
				end
			end
		end
	end

	// table read resolves against a same-cycle write or clear
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_s2 <= cmd;
			byp_s2 <= !reinit && tab_we && (tab_waddr == rd_addr);
			tv_s2 <= !reinit && tvalid_q[rd_addr];
			bdat_s2 <= new_col;
		end
	end

endmodule

// ===== rtl/qoi_chunk_decoder.sv =====
// Top level of the QOI chunk decoder: byte stream in, ARGB pixels out.
//
// Channel   Direction  Handshake               Word
// input     in         push / full             data_byte, end_of_data
// result    out        empty / pop             alpha, red, green, blue, status,
//                                              last_of_run, last_pixel
// config    in         cfg_write (no stall)    cfg_data = pixel_count
//
// One byte per cycle is taken while the 2-word command queue has room.
// A byte that yields one pixel holds the execute stage for that pixel; a run
// byte holds it until every emitted pixel and any early-end word are pushed.
// A result is registered in the command queue, the execute stage and the result queue.
// Reset is asynchronous; table valid flags clear at once, no clearing pass.
`timescale 1ns / 1ps

module qoi_chunk_decoder import qcd_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [31:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        end_of_data,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  alpha,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [1:0]  status,
	output logic        last_of_run,
	output logic        last_pixel
);

	logic [31:0] pixel_count_q;
	logic accept;
	logic fe_vld;
	cmd_t fe_cmd;
	cmd_t cq_head;
	logic cq_full;
	logic cq_empty;
	logic cq_pop;
	res_t be_res;
	logic be_push;
	logic rq_full;
	res_t rq_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_count_q <= 32'd1;
		end else if (cfg_write) begin
			pixel_count_q <= cfg_data;
		end
	end

	assign full = cq_full;
	assign accept = push && !cq_full;

	qcd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.data_byte   (data_byte),
		.end_of_data (end_of_data),
		.cmd_vld     (fe_vld),
		.cmd         (fe_cmd)
	);

	qcd_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(CMD_Q_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept && fe_vld),
		.wdata  (fe_cmd),
		.full   (cq_full),
		.pop    (cq_pop),
		.rdata  (cq_head),
		.empty  (cq_empty)
	);

	qcd_back #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_count (pixel_count_q),
		.cmd         (cq_head),
		.cmd_empty   (cq_empty),
		.cmd_pop     (cq_pop),
		.res         (be_res),
		.res_push    (be_push),
		.res_full    (rq_full)
	);

	qcd_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(RES_Q_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (be_push),
		.wdata  (be_res),
		.full   (rq_full),
		.pop    (pop),
		.rdata  (rq_head),
		.empty  (empty)
	);

	assign alpha = rq_head.a;
	assign red = rq_head.r;
	assign green = rq_head.g;
	assign blue = rq_head.b;
	assign status = rq_head.status;
	assign last_of_run = rq_head.lor;
	assign last_pixel = rq_head.lp;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for qoi_chunk_decoder: chunk byte stream in, predicted pixel words checked out.
`timescale 1ns / 1ps

module testbench;
	import qcd_pkg::*;

	typedef enum {END_FULL, END_EARLY, END_CUT} image_end_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [31:0] cfg_data = '0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  data_byte = '0;
	logic        end_of_data = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [7:0]  alpha;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [1:0]  status;
	logic        last_of_run;
	logic        last_pixel;

	qoi_chunk_decoder dut (.*);

	class pixel_predictor;
		logic [31:0] pixel_total;
		logic [7:0]  pr, pg, pb, pa;
		logic [31:0] palette [64];
		logic [31:0] pixels_out;
		logic [7:0]  tag;
		int unsigned owed;
		bit          image_done;
		res_t        pending [$];
		int          mismatches;

		function new();
			pixel_total = 1;
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			pr = '0;
			pg = '0;
			pb = '0;
			pa = 8'hff;
			foreach (palette[i]) palette[i] = '0;
			pixels_out = '0;
			tag = '0;
			owed = 0;
			image_done = 1'b0;
		endfunction

		function void remember();
			int h;
			h = int'(3 * pr + 5 * pg + 7 * pb + 11 * pa) & 63;
			palette[h] = {pa, pr, pg, pb};
		endfunction

		function void put_pixel();
			res_t r;
			pixels_out = pixels_out + 1;
			r.a = pa;
			r.r = pr;
			r.g = pg;
			r.b = pb;
			r.status = ST_PIXEL;
			r.lor = 1'b0;
			r.lp = (pixels_out == pixel_total);
			if (r.lp)
				image_done = 1'b1;
			pending.push_back(r);
		endfunction

		function void put_status(status_t s);
			res_t r;
			r = '0;
			r.status = s;
			pending.push_back(r);
		endfunction

		function void take_byte(logic [7:0] b, logic eod);
			int first;
			int dg, dr, db;
			int unsigned spot, run, left;
			res_t r;
			first = pending.size();
			if (image_done) begin
				if (eod)
					restart();
				return;
			end
			if (owed > 0) begin
				if (tag[7:6] == CL_LUMA) begin
					dg = int'(tag[5:0]) - 32;
					dr = dg - 8 + int'(b[7:4]);
					db = dg - 8 + int'(b[3:0]);
					pr = pr + 8'(dr);
					pg = pg + 8'(dg);
					pb = pb + 8'(db);
					owed = 0;
				end else begin
					spot = (tag == TAG_RGBA) ? 4 - owed : 3 - owed;
					case (spot)
						0: pr = b;
						1: pg = b;
						2: pb = b;
						default: pa = b;
					endcase
					owed--;
				end
				if (owed == 0) begin
					remember();
					put_pixel();
				end
			end else if (b == TAG_RGB || b == TAG_RGBA) begin
				tag = b;
				owed = (b == TAG_RGBA) ? 4 : 3;
			end else if (b[7:6] == CL_INDEX) begin
				{pa, pr, pg, pb} = palette[b[5:0]];
				remember();
				put_pixel();
			end else if (b[7:6] == CL_DIFF) begin
				pr = pr + 8'(int'(b[5:4]) - 2);
				pg = pg + 8'(int'(b[3:2]) - 2);
				pb = pb + 8'(int'(b[1:0]) - 2);
				remember();
				put_pixel();
			end else if (b[7:6] == CL_LUMA) begin
				tag = b;
				owed = 1;
			end else begin
				run = b[5:0] + 1;
				left = pixel_total - pixels_out;
				if (left == 0)
					left = 64;
				if (run > left)
					run = left;
				// room for the early-end word
				if (eod && run == RUN_MAX && run < left)
					run = RUN_MAX - 1;
				remember();
				repeat (run) put_pixel();
			end
			if (eod) begin
				if (owed > 0)
					put_status(ST_CUT);
				else if (!image_done)
					put_status(ST_EARLY);
				restart();
			end
			if (pending.size() > first) begin
				r = pending.pop_back();
				r.lor = 1'b1;
				pending.push_back(r);
			end
		endfunction

		function void match_pixel(res_t got);
			res_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: a=%h r=%h g=%h b=%h st=%0d lor=%b lp=%b",
						got.a, got.r, got.g, got.b, got.status, got.lor, got.lp);
				return;
			end
			want = pending.pop_front();
			if (got.a !== want.a || got.r !== want.r || got.g !== want.g ||
					got.b !== want.b || got.status !== want.status ||
					got.lor !== want.lor || got.lp !== want.lp) begin
				mismatches++;
				if (mismatches <= 10)
					$display("word mismatch: exp a=%h r=%h g=%h b=%h st=%0d lor=%b lp=%b, got a=%h r=%h g=%h b=%h st=%0d lor=%b lp=%b",
						want.a, want.r, want.g, want.b, want.status, want.lor, want.lp,
						got.a, got.r, got.g, got.b, got.status, got.lor, got.lp);
			end
		endfunction
	endclass

	pixel_predictor pred;
	int             bytes_sent = 0;
	bit             hold_req = 1'b0;
	bit             fast_tx = 1'b0;
	logic [7:0]     chunk_q [$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("[qoi_chunk_decoder] ERROR");
		$finish;
	end

	task automatic send_word(logic [7:0] b, logic eod);
		int gap;
		gap = fast_tx ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		end_of_data <= eod;
		@(posedge clk);
		while (full) @(posedge clk);
		pred.take_byte(b, eod);
		bytes_sent++;
	endtask

	task automatic set_pixel_count(logic [31:0] v);
		push <= 1'b0;
		while (pred.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_write <= 1'b0;
		pred.pixel_total = v;
	endtask

	function automatic void make_chunk(op_t op);
		int n;
		chunk_q.delete();
		case (op)
			OP_RGB: begin
				chunk_q.push_back(TAG_RGB);
				repeat (3) chunk_q.push_back(8'($urandom));
			end
			OP_RGBA: begin
				chunk_q.push_back(TAG_RGBA);
				repeat (4) chunk_q.push_back(8'($urandom));
			end
			OP_INDEX: chunk_q.push_back({CL_INDEX, 6'($urandom)});
			OP_DIFF: chunk_q.push_back({CL_DIFF, 6'($urandom)});
			OP_LUMA: begin
				chunk_q.push_back({CL_LUMA, 6'($urandom)});
				chunk_q.push_back(8'($urandom));
			end
			default: begin
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, RUN_MAX - 1)
					: $urandom_range(0, 7);
				chunk_q.push_back({CL_RUN, 6'(n)});
			end
		endcase
	endfunction

	function automatic void next_chunk(bit noise);
		if (noise) begin
			chunk_q.delete();
			chunk_q.push_back(8'($urandom));
		end else
			make_chunk(op_t'($urandom_range(0, 5)));
	endfunction

	task automatic send_chunk(int eod_at);
		foreach (chunk_q[i]) send_word(chunk_q[i], i == eod_at);
	endtask

	task automatic send_image(logic [31:0] count, image_end_t how, bit noise);
		int chunks, i, k;
		set_pixel_count(count);
		fast_tx = ($urandom_range(0, 3) == 0);
		case (how)
			END_FULL: begin
				k = 0;
				while (!pred.image_done && k < 400) begin
					next_chunk(noise);
					send_chunk(-1);
					k++;
				end
				repeat ($urandom_range(0, 3)) send_word(8'($urandom), 1'b0);
				send_word(8'($urandom), 1'b1);
			end
			END_EARLY: begin
				chunks = $urandom_range(1, 12);
				for (i = 0; i < chunks; i++) begin
					next_chunk(noise);
					send_chunk(i == chunks - 1 ? chunk_q.size() - 1 : -1);
				end
			end
			default: begin
				chunks = $urandom_range(0, 8);
				for (i = 0; i < chunks; i++) begin
					next_chunk(noise);
					send_chunk(-1);
				end
				k = $urandom_range(0, 2);
				make_chunk(k == 0 ? OP_RGB : k == 1 ? OP_RGBA : OP_LUMA);
				send_chunk($urandom_range(0, chunk_q.size() - 2));
			end
		endcase
	endtask

	initial begin : receiver
		int gap;
		int words;
		bit held;
		bit rx_fast;
		words = 0;
		held = 1'b0;
		rx_fast = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (words % 32 == 0)
				rx_fast = ($urandom_range(0, 3) == 0);
			if (hold_req && !held) begin
				held = 1'b1;
				gap = 400;
			end else
				gap = rx_fast ? 0 : $urandom_range(0, 7);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			pred.match_pixel(res_t'{alpha, red, green, blue, status_t'(status),
				last_of_run, last_pixel});
			words++;
		end
	end

	initial begin : stimulus
		logic [31:0] count;
		image_end_t how;
		bit noise;
		int pick, k;
		pred = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_pixel_count(10);
		send_word(TAG_RGB, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'hff, 1'b0);
		send_word(8'h80, 1'b0);
		send_word(TAG_RGBA, 1'b0);
		send_word(8'hff, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'h7f, 1'b0);
		send_word(8'h00, 1'b0);
		send_word({CL_INDEX, 6'h35}, 1'b0);
		send_word({CL_DIFF, 6'h00}, 1'b0);
		send_word({CL_DIFF, 6'h3f}, 1'b0);
		send_word({CL_LUMA, 6'h00}, 1'b0);
		send_word(8'h00, 1'b0);
		send_word({CL_LUMA, 6'h3f}, 1'b0);
		send_word(8'hff, 1'b0);
		send_word({CL_INDEX, 6'h3f}, 1'b0);
		send_word({CL_RUN, 6'h00}, 1'b0);
		// run past the end of the image, then ignored bytes
		send_word({CL_RUN, 6'h3d}, 1'b0);
		send_word(8'h55, 1'b0);
		send_word(8'h00, 1'b1);
		// full run on the last byte, image still open
		set_pixel_count(100);
		send_word({CL_RUN, 6'h3d}, 1'b1);
		// chunk cut by end of data
		set_pixel_count(5);
		send_word(TAG_RGBA, 1'b0);
		send_word(8'h12, 1'b1);

		// long receiver hold-off while this image streams in
		hold_req = 1'b1;
		send_image(200, END_FULL, 1'b0);

		while (bytes_sent < 525) begin
			pick = $urandom_range(0, 9);
			case (pick)
				0: count = 1;
				1: count = 32'hffff_ffff;
				2: count = 0;
				9: count = $urandom_range(41, 250);
				default: count = $urandom_range(2, 40);
			endcase
			if (count == 0 || count == 32'hffff_ffff)
				how = $urandom_range(0, 1) ? END_EARLY : END_CUT;
			else begin
				k = $urandom_range(0, 3);
				how = k < 2 ? END_FULL : k == 2 ? END_EARLY : END_CUT;
			end
			noise = ($urandom_range(0, 4) == 0);
			send_image(count, how, noise);
		end
		push <= 1'b0;

		k = 0;
		while (pred.pending.size() != 0 && k < 200000) begin
			@(posedge clk);
			k++;
		end
		repeat (20) @(posedge clk);
		if (pred.mismatches == 0 && pred.pending.size() == 0)
			$display("[qoi_chunk_decoder] OK");
		else
			$display("[qoi_chunk_decoder] ERROR");
		$finish;
	end

endmodule
